FILE: rtl/radix_digit_converter_assert.svh
// ----------------------------------------------------------------------------
// radix_digit_converter assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("radix_digit_converter: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("radix_digit_converter: assertion failed");

`endif

FILE: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Constants and helpers shared by the radix digit converter modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Number of input bits that take part in the conversion
  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int NUM_W      = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;

  // Divider works two quotient bits per cycle on an even-width dividend
  localparam int DIV_W      = NUM_W + (NUM_W % 2);
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // Radix register and digit widths
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // Digit stack: at most NUM_W digits (base two)
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int PTR_W      = $clog2(NUM_W);

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_A     = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  // Digit value to ASCII: '0'..'9' then 'A' onward
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DEC_DIGITS) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    end
    return ch;
  endfunction

endpackage

FILE: rtl/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider
// Iterative restoring divider, two quotient bits per cycle, narrow divisor.
// ----------------------------------------------------------------------------
module rdc_divider import rdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    dividend_i,
  input  logic [RADIX_W-1:0]  divisor_i,
  output logic                done_o,
  output logic [NUM_W-1:0]    quotient_o,
  output logic [DIGIT_W-1:0]  remainder_o
);

  localparam logic [STEP_W-1:0] StepOne = STEP_W'(1);

  logic [DIV_W-1:0]   acc_q, acc_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic               done_q, done_d;

  logic [DIGIT_W:0]   dvs;
  logic [DIGIT_W:0]   p1, p2, s1, s2;
  logic [DIGIT_W-1:0] r1, r2;
  logic               qb1, qb0;

  // Two dependent compare-subtract steps on the partial remainder
  always_comb begin
    dvs = {1'b0, divisor_i};
    p1  = {rem_q, acc_q[DIV_W-1]};
    qb1 = (p1 >= dvs);
    s1  = p1 - dvs;
    r1  = qb1 ? s1[DIGIT_W-1:0] : p1[DIGIT_W-1:0];
    p2  = {r1, acc_q[DIV_W-2]};
    qb0 = (p2 >= dvs);
    s2  = p2 - dvs;
    r2  = qb0 ? s2[DIGIT_W-1:0] : p2[DIGIT_W-1:0];
  end

  // Step sequencing; quotient bits shift in as dividend bits shift out
  always_comb begin
    acc_d   = acc_q;
    rem_d   = rem_q;
    steps_d = steps_q;
    done_d  = 1'b0;
    if (start_i) begin
      acc_d   = DIV_W'(dividend_i);
      rem_d   = '0;
      steps_d = STEP_W'(DIV_STEPS);
    end else if (steps_q != '0) begin
      acc_d   = {acc_q[DIV_W-3:0], qb1, qb0};
      rem_d   = r2;
      steps_d = steps_q - StepOne;
      done_d  = (steps_q == StepOne);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      steps_q <= steps_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = acc_q[NUM_W-1:0];
  assign remainder_o = rem_q;

endmodule

FILE: rtl/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter
// Writes an unsigned integer as ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// One value is taken at a time. Digits are produced least significant first
// by repeated division on one shared divider, kept in a small digit stack,
// then sent most significant first, one request per digit, the final digit
// flagged by last_digit_o. Each digit takes one pass through the divider,
// two quotient bits a cycle over the 32-bit value, then a hand-over into
// the stack; digits are read from the stack in S_READ and presented in
// S_SEND. In_stall_o stays high from the accepted request until the last
// digit has been taken. The radix register (reset 10) clamps written
// values into 2..36 and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module radix_digit_converter import rdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // radix configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RADIX_W-1:0] cfg_data_i,
  // input requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [IN_W-1:0]    value_i,
  // digit requests
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               last_digit_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_SEND = 4'b1000
  } state_e;

  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);
  localparam logic [PTR_W-1:0] PtrOne = PTR_W'(1);

  state_e             state_q, state_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [DIGIT_W-1:0] rd_q;
  logic [DIGIT_W-1:0] stack_mem [NUM_W];

  logic               in_acc;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_dividend;
  logic [NUM_W-1:0]   div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic               push;

  // Shared divider
  rdc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Radix register with clamping
  assign cfg_ready_o = 1'b1;

  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i) begin
      if (cfg_data_i < RADIX_MIN) begin
        radix_d = RADIX_MIN;
      end else if (cfg_data_i > RADIX_MAX) begin
        radix_d = RADIX_MAX;
      end else begin
        radix_d = cfg_data_i;
      end
    end
  end

  // Sequencer
  assign in_acc       = in_valid_i && (state_q == S_IDLE);
  assign push         = (state_q == S_DIV) && div_done;
  assign div_start    = in_acc || (push && (div_quot != '0));
  assign div_dividend = (state_q == S_IDLE) ? value_i[NUM_W-1:0] : div_quot;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cnt_d = cnt_q + CntOne;
          if (div_quot == '0) begin
            ptr_d   = cnt_q[PTR_W-1:0];
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (!out_stall_i) begin
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q - PtrOne;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      radix_q <= RADIX_RESET;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      radix_q <= radix_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  // Digit stack: written least significant first, read back in reverse
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[cnt_q[PTR_W-1:0]] <= div_rem;
    end
    rd_q <= stack_mem[ptr_q];
  end

  // Outputs
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_SEND);
  assign digit_char_o = digit_ascii(rd_q);
  assign last_digit_o = (ptr_q == '0);

endmodule

FILE: rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks on the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix_digit_converter_assert.svh"

module rdc_checker import rdc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CHAR_W-1:0]  digit_char_o,
  input logic               last_digit_o
);

  logic char_ok;
  logic in_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign char_ok = ((digit_char_o >= CHAR_ZERO) && (digit_char_o <= CHAR_W'(57))) ||
                   ((digit_char_o >= CHAR_A) && (digit_char_o <= CHAR_W'(90)));

  // A stalled digit request holds its payload
  `RDC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(digit_char_o) && $stable(last_digit_o))

  // No new value is taken while digits are still being sent
  `RDC_ASSERT_IMP(a_busy_when_sending, clk_i, rst_ni, out_valid_o, in_stall_o)

  // An accepted value always makes the block busy next cycle
  `RDC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)

  // Every digit is a legal character
  `RDC_ASSERT_IMP(a_char_legal, clk_i, rst_ni, out_valid_o, char_ok)

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

FILE: verif/radix_digit_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_test
// Self-checking testbench for the radix digit converter. Values are sent on
// the input channel, every expected ASCII digit is worked out here and
// queued, and each digit request taken from the block is checked in order.
// Radix settings, clamping of out-of-range writes and random traffic with
// random idling on both sides are covered.
// ----------------------------------------------------------------------------
module radix_digit_converter_test;
  import rdc_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_GAP      = 11;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 40;
  localparam int MAX_REPORTS  = 30;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  // Block ports; every input is at a known value from time zero
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [RADIX_W-1:0] cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [IN_W-1:0]    value_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_digit_o;

  // Predictor state and bookkeeping
  logic [RADIX_W-1:0] radix_model  = RADIX_RESET;
  digit_t             digit_queue[$];
  bit                 pace_idle    = 1'b1;
  int                 error_count  = 0;
  int                 value_count  = 0;
  int                 digit_count  = 0;
  int                 radix_writes = 0;
  int                 cycle_count  = 0;

  radix_digit_converter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  // Clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d digits pending",
               cycle_count, digit_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Register write data clamped into the legal base range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] r;
    r = d;
    if (r < RADIX_MIN) r = RADIX_MIN;
    if (r > RADIX_MAX) r = RADIX_MAX;
    return r;
  endfunction

  // One digit value as an ASCII character
  function automatic logic [CHAR_W-1:0] ascii_of(input int unsigned d);
    logic [CHAR_W-1:0] ch;
    if (d < 10) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d - 10);
    end
    return ch;
  endfunction

  // Queue the digits of one value, most significant first
  task automatic queue_digits(input logic [IN_W-1:0] v);
    logic [NUM_W-1:0]  rest;
    logic [CHAR_W-1:0] chars[$];
    int unsigned       d;
    digit_t            item;
    rest = v[NUM_W-1:0];
    do begin
      d    = rest % radix_model;
      chars.push_front(ascii_of(d));
      rest = rest / radix_model;
    end while (rest != 0);
    foreach (chars[k]) begin
      item.ch   = chars[k];
      item.last = (k == chars.size() - 1);
      digit_queue.push_back(item);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
  endtask

  // Send one value request; valid is left high so back-to-back requests flow
  task automatic send_value(input logic [IN_W-1:0] v);
    int gap;
    gap = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    queue_digits(v);
    value_count++;
  endtask

  // Drop the input request and wait until every queued digit has come
  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (digit_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Radix write, only ever issued with the block idle
  task automatic write_radix(input logic [RADIX_W-1:0] d);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radix_model = clamp_radix(d);
    radix_writes++;
    @(posedge clk_i);
  endtask

  // Random value with a spread of magnitudes so digit counts vary
  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = IN_W'($urandom) >> $urandom_range(0, IN_W - 1);
      4:       v = IN_W'($urandom_range(0, 40));
      default: v = IN_W'($urandom);
    endcase
    return v;
  endfunction

  // Digit checker with a random stall drawn per digit when idling is on
  initial begin
    int     gap;
    digit_t want;
    wait (rst_ni);
    forever begin
      gap = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      digit_count++;
      if (digit_queue.size() == 0) begin
        report_mismatch("unexpected digit request, char", digit_char_o, 0);
      end else begin
        want = digit_queue.pop_front();
        if (digit_char_o !== want.ch)
          report_mismatch("digit_char", digit_char_o, want.ch);
        if (last_digit_o !== want.last)
          report_mismatch("last_digit", last_digit_o, want.last);
      end
    end
  end

  // Reset value of the radix is ten
  task automatic test_reset_radix();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
  endtask

  // Base extremes, clamping of out-of-range writes and hex
  task automatic test_radix_extremes();
    write_radix(RADIX_W'(2));
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    write_radix(RADIX_W'(36));
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'hFFFF_FFFF);
    // below two clamps to two
    write_radix(RADIX_W'(0));
    send_value(32'd5);
    write_radix(RADIX_W'(1));
    send_value(32'd3);
    // above thirty-six clamps to thirty-six
    write_radix(RADIX_W'(37));
    send_value(32'd1295);
    write_radix(RADIX_W'(63));
    send_value(32'hFFFF_FFFF);
    write_radix(RADIX_W'(16));
    send_value(32'hDEAD_BEEF);
    send_value(32'h0000_000F);
  endtask

  // Sender holds off until the block has drained after each value
  task automatic test_drained_sends();
    write_radix(RADIX_W'(7));
    repeat (3) begin
      send_value(pick_value());
      settle();
    end
  endtask

  // Random phases: random radix, idling on or off, occasional drain
  task automatic test_random_traffic();
    logic [RADIX_W-1:0] r;
    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(0, 1)) begin
        r = RADIX_W'($urandom_range(0, 63));
      end else begin
        case ($urandom_range(0, 5))
          0:       r = RADIX_W'(2);
          1:       r = RADIX_W'(3);
          2:       r = RADIX_W'(8);
          3:       r = RADIX_W'(16);
          4:       r = RADIX_W'(35);
          default: r = RADIX_W'(36);
        endcase
      end
      write_radix(r);
      pace_idle = (p % 3) != 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(pick_value());
        if ($urandom_range(0, 39) == 0) settle();
      end
    end
    pace_idle = 1'b1;
  endtask

  // Main sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_radix();
    test_radix_extremes();
    test_drained_sends();
    test_random_traffic();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d values converted to %0d digits across %0d radix writes",
             value_count, digit_count, radix_writes);
    $display("%0d mismatches in %0d cycles", error_count, cycle_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
